[sv/rsmb_pkg.sv]
// ----------------------------------------------------------------------------
// rsmb_pkg
// Shared types, codes and reset values of the random spanning maze builder.
// ----------------------------------------------------------------------------
package rsmb_pkg;

  localparam int DEF_MAX_COLS = 16;
  localparam int DEF_MAX_ROWS = 16;

  localparam int DIM_W = 5;
  localparam int POS_W = 4;
  localparam int GRID_W = 6;
  localparam int COMP_W = 9;
  localparam int KIND_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_COL = 2'd3;

  localparam logic [DIM_W-1:0] RST_COLS_IN_USE = 5'd16;
  localparam logic [DIM_W-1:0] RST_ROWS_IN_USE = 5'd16;
  localparam logic [POS_W-1:0] RST_ENTRY_COL = 4'd0;
  localparam logic [POS_W-1:0] RST_EXIT_COL = 4'd15;

  localparam logic FUNC_RESTART = 1'b0;
  localparam logic FUNC_PROPOSE = 1'b1;

  localparam logic DIR_RIGHT = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  localparam logic [KIND_W-1:0] KIND_RESTARTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NO_CHANGE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXIT = 3'd4;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
    logic             direction;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [GRID_W-1:0] grid_row;
    logic [GRID_W-1:0] grid_col;
    logic [COMP_W-1:0] components_left;
    logic              last;
  } out_item_t;

  // Effective maze settings after clamping.
  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic [POS_W-1:0] entry;
    logic [POS_W-1:0] exit_pos;
  } maze_cfg_t;

endpackage

[sv/rsmb_ram.sv]
// ----------------------------------------------------------------------------
// rsmb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/rsmb_ctrl.sv]
// ----------------------------------------------------------------------------
// rsmb_ctrl
// Sequencer: proposal check, union-find root walks over the parent table
// through one read port and one compare, join write and result emission.
// ----------------------------------------------------------------------------
module rsmb_ctrl
  import rsmb_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  input  maze_cfg_t cfg,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
  localparam int CELL_W = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int IDX_W = $clog2(32 * MAX_COLS + 32);
  localparam int RMAX = (MAX_ROWS < 31) ? MAX_ROWS : 31;
  localparam int CMAX = (MAX_COLS < 31) ? MAX_COLS : 31;
  localparam int CNT_W = $clog2(RMAX * CMAX + 1) + 1;
  localparam int RST_R = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int RST_C = (MAX_COLS < 16) ? MAX_COLS : 16;
  localparam logic [CNT_W-1:0] RST_COUNT = CNT_W'(RST_R * RST_C);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WALK_A = 3'd2;
  localparam logic [2:0] S_WALK_B = 3'd3;
  localparam logic [2:0] S_ENTRY = 3'd4;
  localparam logic [2:0] S_EXIT = 3'd5;

  function automatic logic [CELL_W-1:0] cell_index(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
    logic [IDX_W-1:0] full;
    full = IDX_W'(r) * IDX_W'(MAX_COLS) + IDX_W'(c);
    return full[CELL_W-1:0];
  endfunction

  logic [2:0]            state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [CELL_W-1:0]     cur_r, cur_nxt;
  logic [CELL_W-1:0]     root_a_r, root_a_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CELL_TOTAL-1:0] valid_r;
  logic                  vq_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  valid_clr;
  logic                  ram_we;
  logic [CELL_W-1:0]     ram_q;
  logic [CELL_W-1:0]     link;
  logic                  root_hit;
  logic [2*DIM_W-1:0]    area;
  logic [CNT_W-1:0]      area_cnt;
  logic [DIM_W-1:0]      row_a, col_a, row_b, col_b;
  logic                  in_range, has_nb;
  logic [CNT_W-1:0]      joined_cnt;

  rsmb_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELL_TOTAL)
  ) u_parent (
    .clk  (clk),
    .we   (ram_we),
    .waddr(root_a_r),
    .wdata(cur_r),
    .raddr(cur_nxt),
    .rdata(ram_q)
  );

  assign link = vq_r ? ram_q : cur_r;
  assign root_hit = (link == cur_r);
  assign area = (2*DIM_W)'(cfg.rows) * (2*DIM_W)'(cfg.cols);
  assign area_cnt = CNT_W'(area);
  assign row_a = DIM_W'(item_r.cell_row);
  assign col_a = DIM_W'(item_r.cell_col);
  assign row_b = (item_r.direction == DIR_DOWN) ? row_a + 5'd1 : row_a;
  assign col_b = (item_r.direction == DIR_RIGHT) ? col_a + 5'd1 : col_a;
  assign in_range = (row_a < cfg.rows) && (col_a < cfg.cols);
  assign has_nb = (row_b < cfg.rows) && (col_b < cfg.cols);
  assign joined_cnt = (count_r > CNT_W'(1)) ? count_r - CNT_W'(1) : count_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    cur_nxt = cur_r;
    root_a_nxt = root_a_r;
    count_nxt = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt = '0;
    valid_clr = 1'b0;
    ram_we = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt = in_data;
          if (in_data.func == FUNC_RESTART) begin
            valid_clr = 1'b1;
            count_nxt = area_cnt;
            out_valid_nxt = 1'b1;
            out_data_nxt.kind = KIND_RESTARTED;
            out_data_nxt.last = (area_cnt != CNT_W'(1));
            if (area_cnt == CNT_W'(1)) begin
              state_nxt = S_ENTRY;
            end
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (in_range && has_nb) begin
          cur_nxt = cell_index(row_a, col_a);
          state_nxt = S_WALK_A;
        end else begin
          out_valid_nxt = 1'b1;
          out_data_nxt.kind = KIND_NO_CHANGE;
          out_data_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_WALK_A: begin
        if (root_hit) begin
          root_a_nxt = cur_r;
          cur_nxt = cell_index(row_b, col_b);
          state_nxt = S_WALK_B;
        end else begin
          cur_nxt = link;
        end
      end
      S_WALK_B: begin
        if (!root_hit) begin
          cur_nxt = link;
        end else if (cur_r == root_a_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.kind = KIND_NO_CHANGE;
          out_data_nxt.last = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_we = 1'b1;
          count_nxt = joined_cnt;
          out_valid_nxt = 1'b1;
          out_data_nxt.kind = KIND_WALL;
          if (item_r.direction == DIR_RIGHT) begin
            out_data_nxt.grid_row = GRID_W'({item_r.cell_row, 1'b1});
            out_data_nxt.grid_col = GRID_W'({item_r.cell_col, 1'b0}) + 6'd2;
          end else begin
            out_data_nxt.grid_row = GRID_W'({item_r.cell_row, 1'b0}) + 6'd2;
            out_data_nxt.grid_col = GRID_W'({item_r.cell_col, 1'b1});
          end
          if ((count_r > CNT_W'(1)) && (joined_cnt == CNT_W'(1))) begin
            out_data_nxt.last = 1'b0;
            state_nxt = S_ENTRY;
          end else begin
            out_data_nxt.last = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_ENTRY: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.kind = KIND_ENTRY;
        out_data_nxt.grid_col = GRID_W'({cfg.entry, 1'b1});
        state_nxt = S_EXIT;
      end
      S_EXIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt.kind = KIND_EXIT;
        out_data_nxt.grid_row = GRID_W'({cfg.rows, 1'b0});
        out_data_nxt.grid_col = GRID_W'({cfg.exit_pos, 1'b1});
        out_data_nxt.last = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_data_nxt.components_left = COMP_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= RST_COUNT;
      valid_r <= '0;
      out_valid_r <= 1'b0;
      cur_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r <= cur_nxt;
      if (valid_clr) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[root_a_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    root_a_r <= root_a_nxt;
    vq_r <= valid_r[cur_nxt];
    out_data_r <= out_data_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

[sv/random_spanning_maze_builder.sv]
// ----------------------------------------------------------------------------
// random_spanning_maze_builder
// Random spanning-tree maze builder over a union-find parent table; streams
// opened walls and, once one set remains, the entry and exit openings.
// ----------------------------------------------------------------------------
// A restart gives its result in the next cycle; on a one-cell maze the entry
// and then the exit opening follow it. A proposal passes through S_CHECK, a
// walk from the first cell to its root in S_WALK_A and a walk from the
// neighbour to its root in S_WALK_B, then S_ENTRY and S_EXIT when the openings
// follow: both root walks go through the parent table one link per cycle on
// its single registered read port. busy is high from the cycle after a
// proposal is taken until its last result is under way, and while the
// openings of a one-cell restart go out; any other restart leaves it low, so
// the next command can follow at once. Results come one per cycle, each on
// out_data for exactly one cycle with out_valid high; the receiver cannot
// stall them and must take each transfer as it appears. A restart clears the
// table at once through per-cell valid bits, so no clearing pass is needed.
module random_spanning_maze_builder
  import rsmb_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0] cols_r, rows_r;
  logic [POS_W-1:0] entry_r, exit_r;
  logic [DIM_W-1:0] eff_cols, eff_rows;
  maze_cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= RST_COLS_IN_USE;
      rows_r <= RST_ROWS_IN_USE;
      entry_r <= RST_ENTRY_COL;
      exit_r <= RST_EXIT_COL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS_IN_USE: cols_r <= cfg_data;
        REG_ROWS_IN_USE: rows_r <= cfg_data;
        REG_ENTRY_COL:   entry_r <= cfg_data[POS_W-1:0];
        REG_EXIT_COL:    exit_r <= cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_cols = (cols_r == '0) ? DIM_W'(1) :
                    (32'(cols_r) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_r;
  assign eff_rows = (rows_r == '0) ? DIM_W'(1) :
                    (32'(rows_r) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_r;

  assign cfg.cols = eff_cols;
  assign cfg.rows = eff_rows;
  assign cfg.entry = (DIM_W'(entry_r) < eff_cols) ? entry_r :
                     POS_W'(eff_cols - DIM_W'(1));
  assign cfg.exit_pos = (DIM_W'(exit_r) < eff_cols) ? exit_r :
                        POS_W'(eff_cols - DIM_W'(1));

  rsmb_ctrl #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .cfg      (cfg),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  a_exit_after_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_EXIT) |->
      $past(out_valid && out_data.kind == KIND_ENTRY))
    else $error("exit opening without entry opening before it");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("result burst ended without a last transfer");

  a_proposal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.func == FUNC_PROPOSE) |=> busy)
    else $error("proposal accepted but block not busy");

  a_sets_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.components_left != '0))
    else $error("no sets left in a result");

endmodule

[verif/random_spanning_maze_builder_checker.sv]
// ----------------------------------------------------------------------------
// random_spanning_maze_builder_checker
// Watches the command, result and register ports of the maze builder. It keeps
// its own union-find table and maze settings, and works out the walls, border
// openings and set counts that each accepted command must produce. Each result
// transfer is compared field by field with the oldest pending event.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module random_spanning_maze_builder_checker
  import rsmb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;

  logic [7:0]       link [CELLS];
  int unsigned      set_total;
  logic [DIM_W-1:0] cols_q;
  logic [DIM_W-1:0] rows_q;
  logic [POS_W-1:0] entry_q;
  logic [POS_W-1:0] exit_q;
  out_item_t        maze_events [$];
  out_item_t        want;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned find_set(int unsigned node);
    int unsigned at;
    at = node;
    for (int n = 0; n < CELLS; n++) begin
      if (link[at] == at) break;
      at = link[at];
    end
    return at;
  endfunction

  task automatic clear_sets();
    for (int i = 0; i < CELLS; i++) link[i] = i[7:0];
    set_total = clamp_dim(rows_q, DEF_MAX_ROWS) * clamp_dim(cols_q, DEF_MAX_COLS);
  endtask

  task automatic post_event(logic [KIND_W-1:0] kind, int unsigned row, int unsigned col);
    out_item_t ev;
    ev.kind            = kind;
    ev.grid_row        = row[GRID_W-1:0];
    ev.grid_col        = col[GRID_W-1:0];
    ev.components_left = set_total[COMP_W-1:0];
    ev.last            = 1'b0;
    maze_events.push_back(ev);
  endtask

  task automatic post_border();
    int unsigned cols;
    int unsigned ent;
    int unsigned ext;
    cols = clamp_dim(cols_q, DEF_MAX_COLS);
    ent  = (entry_q < cols) ? entry_q : cols - 1;
    ext  = (exit_q < cols) ? exit_q : cols - 1;
    post_event(KIND_ENTRY, 0, 2 * ent + 1);
    post_event(KIND_EXIT, 2 * clamp_dim(rows_q, DEF_MAX_ROWS), 2 * ext + 1);
  endtask

  task automatic advance_maze(in_item_t it);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned r2;
    int unsigned c2;
    int unsigned ra;
    int unsigned rb;
    bit          joinable;
    bit          done;
    rows = clamp_dim(rows_q, DEF_MAX_ROWS);
    cols = clamp_dim(cols_q, DEF_MAX_COLS);
    if (it.func == FUNC_RESTART) begin
      clear_sets();
      post_event(KIND_RESTARTED, 0, 0);
      if (set_total == 1) post_border();
    end else begin
      r        = it.cell_row;
      c        = it.cell_col;
      r2       = r;
      c2       = c;
      joinable = (r < rows) && (c < cols);
      if (joinable) begin
        if (it.direction == DIR_RIGHT) begin
          c2       = c + 1;
          joinable = (c2 < cols);
        end else begin
          r2       = r + 1;
          joinable = (r2 < rows);
        end
      end
      if (joinable) begin
        ra       = find_set(r * DEF_MAX_COLS + c);
        rb       = find_set(r2 * DEF_MAX_COLS + c2);
        joinable = (ra != rb);
      end
      if (joinable) begin
        link[ra] = rb[7:0];
        done     = 1'b0;
        if (set_total > 1) begin
          set_total--;
          done = (set_total == 1);
        end
        if (it.direction == DIR_RIGHT) post_event(KIND_WALL, 2 * r + 1, 2 * c + 2);
        else post_event(KIND_WALL, 2 * r + 2, 2 * c + 1);
        if (done) post_border();
      end else begin
        post_event(KIND_NO_CHANGE, 0, 0);
      end
    end
    maze_events[maze_events.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(string name, logic [COMP_W-1:0] exp_v, logic [COMP_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cols_q     = RST_COLS_IN_USE;
      rows_q     = RST_ROWS_IN_USE;
      entry_q    = RST_ENTRY_COL;
      exit_q     = RST_EXIT_COL;
      mismatches = 0;
      clear_sets();
      maze_events.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (maze_events.size() == 0) begin
          $error("kind: expected none, actual %0d", out_data.kind);
          mismatches++;
        end else begin
          want = maze_events.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("grid_row", want.grid_row, out_data.grid_row);
          check_field("grid_col", want.grid_col, out_data.grid_col);
          check_field("components_left", want.components_left, out_data.components_left);
          check_field("last", want.last, out_data.last);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COLS_IN_USE: cols_q  = cfg_data;
          REG_ROWS_IN_USE: rows_q  = cfg_data;
          REG_ENTRY_COL:   entry_q = cfg_data[POS_W-1:0];
          REG_EXIT_COL:    exit_q  = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) advance_maze(in_data);
    end
    outstanding = maze_events.size();
  end

endmodule

[verif/random_spanning_maze_builder_tb.sv]
// ----------------------------------------------------------------------------
// random_spanning_maze_builder_tb
// Drives the maze builder with a directed set of joins, duplicate joins, edge
// cells and size extremes, then with random maze phases: each phase writes the
// maze size and border openings, mostly restarts, and proposes walls until
// the phase ends, mixed with raw noise commands and rare restarts. The checker
// judges every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module random_spanning_maze_builder_tb;
  import rsmb_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 370;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    mismatches;
  int                    outstanding;
  int unsigned           cycle_count = 0;
  int                    burst_left  = 0;
  int unsigned           maze_cols   = DEF_MAX_COLS;
  int unsigned           maze_rows   = DEF_MAX_ROWS;
  int unsigned           dim_edges [5] = '{0, 1, 2, 16, 31};

  random_spanning_maze_builder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  random_spanning_maze_builder_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t item_of(logic f, int unsigned row, int unsigned col, logic dir);
    in_item_t it;
    it.func      = f;
    it.cell_row  = row[POS_W-1:0];
    it.cell_col  = col[POS_W-1:0];
    it.direction = dir;
    return it;
  endfunction

  // hold the command until a transfer, return at the following falling edge
  task automatic send_item(in_item_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic feed(in_item_t it);
    if (burst_left == 0) begin
      hold_off($urandom_range(1, 25));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_maze(int unsigned cols, int unsigned rows,
                          int unsigned entry, int unsigned exit_pos);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COLS_IN_USE;
    cfg_data  <= cols[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data  <= rows[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= REG_ENTRY_COL;
    cfg_data  <= entry[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= REG_EXIT_COL;
    cfg_data  <= exit_pos[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    maze_cols = (cols == 0) ? 1 : ((cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cols);
    maze_rows = (rows == 0) ? 1 : ((rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows);
  endtask

  initial begin
    int          sent;
    int          phase_len;
    int          roll;
    logic [31:0] noise;
    sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full 16x16 maze straight out of reset
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 15, 15, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 15, 15, DIR_DOWN));
    feed(item_of(FUNC_PROPOSE, 15, 14, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 14, 15, DIR_DOWN));
    feed(item_of(FUNC_PROPOSE, 15, 0, DIR_DOWN));
    feed(item_of(FUNC_RESTART, 0, 0, DIR_RIGHT));

    // two cells, openings clamped to the last column
    drain();
    set_maze(2, 1, 15, 31);
    feed(item_of(FUNC_RESTART, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_DOWN));
    feed(item_of(FUNC_PROPOSE, 3, 9, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 1, DIR_RIGHT));

    // grow without a restart: the set count stays at one
    drain();
    set_maze(4, 4, 1, 2);
    feed(item_of(FUNC_PROPOSE, 2, 2, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 4, DIR_DOWN));

    // zero size clamps to a single cell
    drain();
    set_maze(0, 0, 0, 0);
    feed(item_of(FUNC_RESTART, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 0, 0, DIR_DOWN));

    // oversize clamps to the full grid
    drain();
    set_maze(31, 31, 15, 15);
    feed(item_of(FUNC_RESTART, 0, 0, DIR_RIGHT));
    feed(item_of(FUNC_PROPOSE, 15, 15, DIR_DOWN));
    feed(item_of(FUNC_PROPOSE, 0, 15, DIR_DOWN));

    while (sent < RANDOM_ITEMS) begin
      drain();
      case ($urandom_range(0, 9))
        0: set_maze(dim_edges[$urandom_range(0, 4)], dim_edges[$urandom_range(0, 4)],
                    $urandom_range(0, 31), $urandom_range(0, 31));
        1: set_maze($urandom_range(6, 16), $urandom_range(6, 16),
                    $urandom_range(0, 31), $urandom_range(0, 31));
        default: set_maze($urandom_range(1, 5), $urandom_range(1, 5),
                          $urandom_range(0, 31), $urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 7) != 0) begin
        feed(item_of(FUNC_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                     1'($urandom_range(0, 1))));
        sent++;
      end
      phase_len = $urandom_range(12, 45);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          feed(item_of(FUNC_RESTART, $urandom_range(0, 15), $urandom_range(0, 15),
                       1'($urandom_range(0, 1))));
        end else if (roll < 13) begin
          noise = $urandom;
          feed(noise[$bits(in_item_t)-1:0]);
        end else begin
          feed(item_of(FUNC_PROPOSE, $urandom_range(0, maze_rows - 1),
                       $urandom_range(0, maze_cols - 1), 1'($urandom_range(0, 1))));
        end
        sent++;
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      if (outstanding != 0) $error("results never arrived: %0d", outstanding);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/rsmb_pkg.sv
sv/rsmb_ram.sv
sv/rsmb_ctrl.sv
sv/random_spanning_maze_builder.sv
verif/random_spanning_maze_builder_checker.sv
verif/random_spanning_maze_builder_tb.sv
